// ===== rtl/pinyin_syllable_splitter_unit_defines.svh =====
// Assertion macros shared by the splitter RTL.
// Each use expands to one labeled concurrent assertion, clocked on clk,
// quiet while rst_n is low.
`ifndef PINYIN_SYLLABLE_SPLITTER_UNIT_DEFINES_SVH
`define PINYIN_SYLLABLE_SPLITTER_UNIT_DEFINES_SVH

// Property must hold at every enabled clock edge.
`define PSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true at an enabled clock edge.
`define PSS_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/pss_pkg.sv =====
package pss_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int RUN_MAX     = 4;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_V     = 8'h76;
    localparam logic [7:0] CH_Z     = 8'h7A;

    typedef enum logic [3:0] {
        MODE_NORMAL    = 4'b0001,
        MODE_AFTER_ZCS = 4'b0010,
        MODE_HELD_N    = 4'b0100,
        MODE_HELD_NG   = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       string_end;
    } in_word_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       run_last;
        logic       output_end;
    } out_word_t;

    // One run of output bytes caused by one input word.
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] chars;
        logic [1:0]              last_idx;
        logic                    last_of_string;
    } run_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    function automatic logic is_vowel(input logic [7:0] c);
        return (c == CH_NUL) || (c == CH_A) || (c == CH_E) || (c == CH_I) ||
               (c == CH_O) || (c == CH_U) || (c == CH_V);
    endfunction

    function automatic logic is_zcs(input logic [7:0] c);
        return (c == CH_Z) || (c == CH_C) || (c == CH_S);
    endfunction

endpackage

// ===== rtl/pss_queue.sv =====
`include "pinyin_syllable_splitter_unit_defines.svh"

module pss_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pss_pkg::run_t       push_run,
    input  logic                pop,
    output pss_pkg::run_t       head_run,
    output pss_pkg::queue_stat_t stat
);

    localparam int AW = pss_pkg::QUEUE_AW;

    pss_pkg::run_t  entry_reg [pss_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [AW:0]    count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_run;
        end
    end

    assign head_run   = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == (AW+1)'(pss_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

    `PSS_ASSERT_NEVER(a_no_push_full, push && stat.full, "run pushed into full queue")
    `PSS_ASSERT_NEVER(a_no_pop_empty, pop && stat.empty, "run popped from empty queue")

endmodule

// ===== rtl/pss_front.sv =====
`include "pinyin_syllable_splitter_unit_defines.svh"

module pss_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pss_pkg::in_word_t    in_word,
    input  pss_pkg::queue_stat_t stat,
    output logic                 push,
    output pss_pkg::run_t        push_run
);

    pss_pkg::mode_t mode_reg, mode_next;
    logic           at_first_reg, at_first_next;
    logic           held_first_reg, held_first_next;

    logic [7:0]                        c;
    logic                              e;
    logic                              accept;
    logic [2:0]                        num;
    pss_pkg::mode_t                    mode_go;
    logic                              held_first_go;
    logic [pss_pkg::RUN_MAX-1:0][7:0]  chars;

    assign c        = in_word.char_in;
    assign e        = in_word.string_end;
    assign in_ready = !stat.full;
    assign accept   = in_valid && in_ready;

    // Classify the word against the pending state and build its run.
    always_comb
    begin
        chars         = {pss_pkg::RUN_MAX{pss_pkg::CH_SPACE}};
        num           = 3'd0;
        mode_go       = pss_pkg::MODE_NORMAL;
        held_first_go = held_first_reg;
        if ((mode_reg == pss_pkg::MODE_AFTER_ZCS) && (c == pss_pkg::CH_H))
        begin
            chars[0] = pss_pkg::CH_H;
            num      = 3'd1;
        end
        else if (mode_reg == pss_pkg::MODE_HELD_N)
        begin
            if (pss_pkg::is_vowel(c))
            begin
                if (held_first_reg)
                begin
                    chars[0] = pss_pkg::CH_N;
                    chars[1] = c;
                    num      = 3'd2;
                end
                else
                begin
                    chars[1] = pss_pkg::CH_N;
                    chars[2] = c;
                    num      = 3'd3;
                end
            end
            else if (c == pss_pkg::CH_G)
            begin
                if (e)
                begin
                    chars[0] = pss_pkg::CH_N;
                    chars[1] = pss_pkg::CH_G;
                    num      = 3'd2;
                end
                else
                begin
                    mode_go = pss_pkg::MODE_HELD_NG;
                end
            end
            else
            begin
                chars[0] = pss_pkg::CH_N;
                chars[2] = c;
                num      = 3'd3;
                if (pss_pkg::is_zcs(c))
                begin
                    mode_go = pss_pkg::MODE_AFTER_ZCS;
                end
            end
        end
        else if (mode_reg == pss_pkg::MODE_HELD_NG)
        begin
            chars[0] = pss_pkg::CH_N;
            chars[3] = c;
            num      = 3'd4;
            if (pss_pkg::is_vowel(c))
            begin
                chars[2] = pss_pkg::CH_G;
            end
            else
            begin
                chars[1] = pss_pkg::CH_G;
                if (pss_pkg::is_zcs(c))
                begin
                    mode_go = pss_pkg::MODE_AFTER_ZCS;
                end
            end
        end
        else
        begin
            if (pss_pkg::is_vowel(c))
            begin
                chars[0] = c;
                num      = 3'd1;
            end
            else if (c == pss_pkg::CH_N)
            begin
                if (e)
                begin
                    chars[0] = pss_pkg::CH_N;
                    num      = 3'd1;
                end
                else
                begin
                    held_first_go = at_first_reg;
                    mode_go       = pss_pkg::MODE_HELD_N;
                end
            end
            else
            begin
                if (at_first_reg)
                begin
                    chars[0] = c;
                    num      = 3'd1;
                end
                else
                begin
                    chars[1] = c;
                    num      = 3'd2;
                end
                if (pss_pkg::is_zcs(c))
                begin
                    mode_go = pss_pkg::MODE_AFTER_ZCS;
                end
            end
        end
    end

    always_comb
    begin
        mode_next       = mode_reg;
        at_first_next   = at_first_reg;
        held_first_next = held_first_reg;
        if (accept)
        begin
            if (e)
            begin
                mode_next       = pss_pkg::MODE_NORMAL;
                at_first_next   = 1'b1;
                held_first_next = 1'b0;
            end
            else
            begin
                mode_next       = mode_go;
                at_first_next   = 1'b0;
                held_first_next = held_first_go;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= pss_pkg::MODE_NORMAL;
            at_first_reg   <= 1'b1;
            held_first_reg <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            at_first_reg   <= at_first_next;
            held_first_reg <= held_first_next;
        end
    end

    // Drop words that resolve to nothing; they only advance the state.
    assign push                    = accept && (num != 3'd0);
    assign push_run.chars          = chars;
    assign push_run.last_idx       = 2'(num - 3'd1);
    assign push_run.last_of_string = e;

    `PSS_ASSERT(a_end_restarts, (accept && e) |=> (mode_reg == pss_pkg::MODE_NORMAL && at_first_reg), "state not restarted after string end")

endmodule

// ===== rtl/pss_back.sv =====
`include "pinyin_syllable_splitter_unit_defines.svh"

module pss_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pss_pkg::run_t        head_run,
    input  pss_pkg::queue_stat_t stat,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pss_pkg::out_word_t   out_word
);

    logic [1:0]          pos_reg, pos_next;
    logic                valid_reg, valid_next;
    pss_pkg::out_word_t  word_reg;
    pss_pkg::out_word_t  word_next;
    logic                load;
    logic                take;
    logic                at_last;

    assign load    = !valid_reg || out_ready;
    assign take    = load && !stat.empty;
    assign at_last = (pos_reg == head_run.last_idx);
    assign pop     = take && at_last;

    always_comb
    begin
        word_next.char_out   = head_run.chars[pos_reg];
        word_next.run_last   = at_last;
        word_next.output_end = at_last && head_run.last_of_string;
        valid_next           = load ? !stat.empty : valid_reg;
        pos_next             = pos_reg;
        if (take)
        begin
            pos_next = at_last ? 2'd0 : pos_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    `PSS_ASSERT(a_end_is_last, (out_valid && out_word.output_end) |-> out_word.run_last, "output_end without run_last")

endmodule

// ===== rtl/pinyin_syllable_splitter_unit.sv =====
// Pinyin syllable splitter. Feed one byte of a romanized string per input
// word (string_end high on its last byte); the block returns the same letters
// with a space inserted at each syllable boundary, one byte per output word.
// Each input word yields zero to four output words: run_last marks the last
// one it caused, and output_end marks the final byte of the string. A held n
// or ng yields nothing until the following byte resolves it. The front stage
// classifies a word in the cycle it is accepted and queues its bytes as one
// run in a 4-entry run queue; it takes a new word every cycle while that
// queue has room. The back stage sends one byte per cycle while out_ready
// is high, through a registered output, so the single-byte output channel
// sets the sustained input rate. An accepted word's run is written into
// the queue, and its first byte then passes through the output register
// before it appears on out_word.
module pinyin_syllable_splitter_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pss_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output pss_pkg::out_word_t out_word
);

    // Runs travel front to back through the queue.
    logic                 push;
    logic                 pop;
    pss_pkg::run_t        push_run;
    pss_pkg::run_t        head_run;
    pss_pkg::queue_stat_t stat;

    // Front: accept a word, resolve held n/ng and zh/ch/sh, build its run.
    pss_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_word  (in_word),
        .stat     (stat),
        .push     (push),
        .push_run (push_run)
    );

    // Queue: decouple the front from output back-pressure.
    pss_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_run (push_run),
        .pop      (pop),
        .head_run (head_run),
        .stat     (stat)
    );

    // Back: serialize each run, one byte per output word.
    pss_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_run  (head_run),
        .stat      (stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule

// ===== sim/tb_pinyin_syllable_splitter_unit.sv =====
`timescale 1ns / 100ps

module tb_pinyin_syllable_splitter_unit;

    // Allow for the worst case: every word in a long gap and every output
    // byte behind a long stall, several times over.
    localparam int RUN_LIMIT    = 300000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_WORDS = 500;

    // One row of the directed script. Where typed is set, bytes holds the
    // expected run (first byte in the top lane) and n its length; other rows
    // take their run from the predictor.
    typedef struct packed {
        logic [7:0]  ch;
        logic        fin;
        logic        typed;
        logic [2:0]  n;
        logic [31:0] bytes;
    } script_row_t;

    localparam int SCRIPT_LEN = 25;

    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        // vowel as first byte passes straight through
        '{pss_pkg::CH_A,     1'b0, 1'b1, 3'd1, {pss_pkg::CH_A, 24'h0}},
        // non-final n, then g after the held n: nothing comes out yet
        '{pss_pkg::CH_N,     1'b0, 1'b1, 3'd0, 32'h0},
        '{pss_pkg::CH_G,     1'b0, 1'b1, 3'd0, 32'h0},
        // held ng resolved by a vowel splits as "n g" plus the vowel
        '{pss_pkg::CH_A,     1'b0, 1'b1, 3'd4,
          {pss_pkg::CH_N, pss_pkg::CH_SPACE, pss_pkg::CH_G, pss_pkg::CH_A}},
        '{pss_pkg::CH_N,     1'b0, 1'b1, 3'd0, 32'h0},
        // held n, not first, before a vowel gets its leading space
        '{pss_pkg::CH_I,     1'b0, 1'b0, 3'd0, 32'h0},
        // held ng followed by n: the n gets its space and is not held
        '{pss_pkg::CH_N,     1'b0, 1'b0, 3'd0, 32'h0},
        '{pss_pkg::CH_G,     1'b0, 1'b0, 3'd0, 32'h0},
        '{pss_pkg::CH_N,     1'b0, 1'b0, 3'd0, 32'h0},
        // zh stays together; a non-h after c is handled normally
        '{pss_pkg::CH_Z,     1'b0, 1'b0, 3'd0, 32'h0},
        '{pss_pkg::CH_H,     1'b0, 1'b0, 3'd0, 32'h0},
        '{pss_pkg::CH_C,     1'b0, 1'b0, 3'd0, 32'h0},
        '{pss_pkg::CH_U,     1'b0, 1'b0, 3'd0, 32'h0},
        // held n broken by s, which then opens sh
        '{pss_pkg::CH_N,     1'b0, 1'b0, 3'd0, 32'h0},
        '{pss_pkg::CH_S,     1'b0, 1'b0, 3'd0, 32'h0},
        '{pss_pkg::CH_H,     1'b0, 1'b0, 3'd0, 32'h0},
        // second n after a held n comes out as "n n"
        '{pss_pkg::CH_N,     1'b0, 1'b0, 3'd0, 32'h0},
        '{pss_pkg::CH_N,     1'b0, 1'b0, 3'd0, 32'h0},
        '{pss_pkg::CH_N,     1'b0, 1'b0, 3'd0, 32'h0},
        // g ending the string flushes "ng"
        '{pss_pkg::CH_G,     1'b1, 1'b1, 3'd2, {pss_pkg::CH_N, pss_pkg::CH_G, 16'h0}},
        // lone n as a whole string comes out at once
        '{pss_pkg::CH_N,     1'b1, 1'b1, 3'd1, {pss_pkg::CH_N, 24'h0}},
        // byte 0 counts as a vowel; 0xFF is a consonant
        '{pss_pkg::CH_NUL,   1'b0, 1'b1, 3'd1, {pss_pkg::CH_NUL, 24'h0}},
        '{8'hFF,             1'b1, 1'b0, 3'd0, 32'h0},
        // held first-byte n before a vowel takes no space
        '{pss_pkg::CH_N,     1'b0, 1'b1, 3'd0, 32'h0},
        '{pss_pkg::CH_E,     1'b1, 1'b0, 3'd0, 32'h0}
    };

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    pss_pkg::in_word_t  in_word;
    logic               out_valid;
    logic               out_ready;
    pss_pkg::out_word_t out_word;

    pinyin_syllable_splitter_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    always #10 clk = ~clk;

    int cycle_count = 0;
    int err_count   = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Expected output words, oldest first.
    pss_pkg::out_word_t spaced_q [$];

    // Idle shaping: when a steady flag is set, that side starts no new gap or
    // stall, so back-to-back stretches show up between the noisy ones.
    bit steady_in  = 1'b0;
    bit steady_out = 1'b0;
    int stall_left = 0;

    // ------------------------------------------------------------------
    // Predictor: its own copy of the splitter state, advanced once per
    // accepted word. The run it computes sits in run_bytes, first byte in
    // the top lane, with run_len bytes valid.
    // ------------------------------------------------------------------
    pss_pkg::mode_t split_mode;
    logic           at_start;
    logic           n_led;
    logic [31:0]    run_bytes;
    int             run_len;

    function automatic logic letter_is_vowel(input logic [7:0] c);
        return c == 8'h00 || c == "a" || c == "e" || c == "i" || c == "o" ||
               c == "u" || c == "v";
    endfunction

    function automatic logic opens_retroflex(input logic [7:0] c);
        return c == "z" || c == "c" || c == "s";
    endfunction

    function void emit(input logic [7:0] c);
        run_bytes[31 - 8 * run_len -: 8] = c;
        run_len++;
    endfunction

    function void split_reset();
        split_mode = pss_pkg::MODE_NORMAL;
        at_start   = 1'b1;
        n_led      = 1'b0;
    endfunction

    task predict_split(input pss_pkg::in_word_t w);
        logic [7:0]     c;
        pss_pkg::mode_t nxt;
        c         = w.char_in;
        nxt       = pss_pkg::MODE_NORMAL;
        run_bytes = '0;
        run_len   = 0;
        if (split_mode == pss_pkg::MODE_AFTER_ZCS && c == "h")
        begin
            // h closes zh/ch/sh with no space
            emit("h");
        end
        else if (split_mode == pss_pkg::MODE_HELD_N)
        begin
            if (letter_is_vowel(c))
            begin
                if (!n_led)
                    emit(" ");
                emit("n");
                emit(c);
            end
            else if (c == "g")
            begin
                if (w.string_end)
                begin
                    emit("n");
                    emit("g");
                end
                else
                begin
                    nxt = pss_pkg::MODE_HELD_NG;
                end
            end
            else
            begin
                emit("n");
                emit(" ");
                emit(c);
                if (opens_retroflex(c))
                    nxt = pss_pkg::MODE_AFTER_ZCS;
            end
        end
        else if (split_mode == pss_pkg::MODE_HELD_NG)
        begin
            emit("n");
            if (letter_is_vowel(c))
            begin
                emit(" ");
                emit("g");
                emit(c);
            end
            else
            begin
                emit("g");
                emit(" ");
                emit(c);
                if (opens_retroflex(c))
                    nxt = pss_pkg::MODE_AFTER_ZCS;
            end
        end
        else
        begin
            if (letter_is_vowel(c))
            begin
                emit(c);
            end
            else if (c == "n")
            begin
                if (w.string_end)
                begin
                    emit("n");
                end
                else
                begin
                    n_led = at_start;
                    nxt   = pss_pkg::MODE_HELD_N;
                end
            end
            else
            begin
                if (!at_start)
                    emit(" ");
                emit(c);
                if (opens_retroflex(c))
                    nxt = pss_pkg::MODE_AFTER_ZCS;
            end
        end
        if (w.string_end)
        begin
            split_reset();
        end
        else
        begin
            split_mode = nxt;
            at_start   = 1'b0;
        end
    endtask

    // Queue one run of expected words; run_last on its last byte, and
    // output_end there too when the word closed the string.
    task queue_run(input logic [31:0] bytes, input int n, input logic fin);
        pss_pkg::out_word_t o;
        for (int i = 0; i < n; i++)
        begin
            o.char_out   = bytes[31 - 8 * i -: 8];
            o.run_last   = (i == n - 1);
            o.output_end = (i == n - 1) && fin;
            spaced_q     = {spaced_q, o};
        end
    endtask

    function int pick_gap();
        int r;
        if (steady_in)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Drive one word, starting and ending at a falling edge. Lower valid
    // only when a gap follows, so valid is never dropped and raised in the
    // same step. Predict at the edge where the handshake completes.
    task send_word(input pss_pkg::in_word_t w, input logic typed, input int tn,
                   input logic [31:0] tbytes);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        predict_split(w);
        if (typed)
            queue_run(tbytes, tn, w.string_end);
        else
            queue_run(run_bytes, run_len, w.string_end);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls, mostly short with a few long ones.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        int r;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (steady_out)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                // hold ready low now and keep it low while stall_left runs down
                stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 30);
                out_ready <= 1'b0;
            end
        end
    end

    // Check every accepted output word against the oldest expectation.
    always @(posedge clk)
    begin
        pss_pkg::out_word_t exp_w;
        if (rst_n && out_valid && out_ready)
        begin
            if (spaced_q.size() == 0)
            begin
                $error("unexpected output word: char_out %h run_last %b output_end %b",
                       out_word.char_out, out_word.run_last, out_word.output_end);
                err_count++;
            end
            else
            begin
                exp_w = spaced_q.pop_front();
                if (out_word.char_out !== exp_w.char_out)
                begin
                    $error("char_out mismatch: expected %h, actual %h",
                           exp_w.char_out, out_word.char_out);
                    err_count++;
                end
                if (out_word.run_last !== exp_w.run_last)
                begin
                    $error("run_last mismatch: expected %b, actual %b",
                           exp_w.run_last, out_word.run_last);
                    err_count++;
                end
                if (out_word.output_end !== exp_w.output_end)
                begin
                    $error("output_end mismatch: expected %b, actual %b",
                           exp_w.output_end, out_word.output_end);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: end the run if it hangs.
    initial
    begin
        wait (cycle_count >= RUN_LIMIT);
        if (spaced_q.size() != 0)
            $error("timeout with %0d expected words still waiting", spaced_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed script, random strings, drain.
    // ------------------------------------------------------------------
    initial
    begin
        pss_pkg::in_word_t w;
        logic [7:0]        c;
        int                len;
        int                pick;
        int                random_words;
        string             letter_pool;

        // Weighted toward the letters that steer the splitter.
        letter_pool  = "aeiouvnnngggghhzcsbdfjklmpqrtwxy";
        random_words = 0;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_word  = '0;
        split_reset();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed script.
        for (int i = 0; i < SCRIPT_LEN; i++)
        begin
            w.char_in    = SCRIPT[i].ch;
            w.string_end = SCRIPT[i].fin;
            send_word(w, SCRIPT[i].typed, int'(SCRIPT[i].n), SCRIPT[i].bytes);
        end

        // Random strings: mostly pinyin-like letters, with stray bytes over
        // the full range and extra n and g to exercise the held states.
        while (random_words < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 7) == 0)
                steady_in = ~steady_in;
            if ($urandom_range(0, 7) == 0)
                steady_out = ~steady_out;
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 78)
                    c = letter_pool[$urandom_range(0, letter_pool.len() - 1)];
                else if (pick < 92)
                    c = 8'($urandom_range(0, 255));
                else if (pick < 96)
                    c = pss_pkg::CH_N;
                else
                    c = pss_pkg::CH_G;
                w.char_in    = c;
                w.string_end = (k == len - 1);
                send_word(w, 1'b0, 0, 32'h0);
                random_words++;
            end
        end

        // Drop valid, let the output side run freely, and wait out the queue.
        in_valid   <= 1'b0;
        steady_out = 1'b1;
        while (spaced_q.size() != 0)
            @(posedge clk);
        // Catch any stray word arriving late.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pss_pkg.sv
rtl/pss_queue.sv
rtl/pss_front.sv
rtl/pss_back.sv
rtl/pinyin_syllable_splitter_unit.sv
sim/tb_pinyin_syllable_splitter_unit.sv
